@@ rtl/core/pidaw_pkg.sv @@
package pidaw_pkg;

    localparam int DATA_WIDTH  = 32;
    localparam int FRAC_BITS   = 16;
    localparam int CFG_INDEX_W = 3;

    typedef enum logic [CFG_INDEX_W-1:0] {
        CFG_PROP_GAIN      = 3'd0,
        CFG_INTEGRAL_GAIN  = 3'd1,
        CFG_DERIV_GAIN     = 3'd2,
        CFG_SAMPLE_PERIOD  = 3'd3,
        CFG_INTEGRAL_UPPER = 3'd4,
        CFG_INTEGRAL_LOWER = 3'd5,
        CFG_DRIVE_UPPER    = 3'd6,
        CFG_DRIVE_LOWER    = 3'd7
    } cfg_index_t;

    typedef enum logic [2:0] {
        MUL_NONE  = 3'd0,
        MUL_PROP  = 3'd1,
        MUL_INT   = 3'd2,
        MUL_PER   = 3'd3,
        MUL_DERIV = 3'd4
    } mul_sel_t;

    typedef struct packed {
        mul_sel_t mul_sel;
        logic     ld_in;
        logic     ld_diff;
        logic     ld_pterm;
        logic     ld_trial;
        logic     ld_integ;
        logic     ld_acc;
        logic     ld_out;
    } dp_cmd_t;

    typedef struct packed {
        logic enable;
    } dp_status_t;

endpackage

@@ rtl/core/pid_step_angle_wrap_antiwindup_top.sv @@
// PID step with angle wrap and conditional-integration anti-windup, Q16.16.
// Input channel (in_valid/in_ready): one beat per sample carrying target,
// measured, angle_mode and enable. Output channel (out_valid/out_ready): one
// beat per input beat with drive and clamped, in order.
// Config: cfg_we writes cfg_data into register cfg_index at the clock edge;
// write only while no sample is in flight.
// An enabled sample is computed from five products issued through one
// shared multiplier plus the add/compare steps between them; a disabled
// sample skips them and goes from the difference step to the output step.
// in_ready is high only while the sequencer is idle, so a new sample is not
// accepted until the previous one has been loaded into the output register.
// Reset clears the integral sum and previous measurement and loads the
// default gains and limits. When the receiver stalls, the result holds in the
// output register; the next sample is still accepted and computed, and it
// waits in its final step until the output register frees.
module pid_step_angle_wrap_antiwindup_top #(
    parameter int DATA_WIDTH = pidaw_pkg::DATA_WIDTH,
    parameter int FRAC_BITS  = pidaw_pkg::FRAC_BITS,
    parameter int CFG_WIDTH  = (DATA_WIDTH > FRAC_BITS + 1) ? DATA_WIDTH : FRAC_BITS + 1
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              in_valid,
    output logic                              in_ready,
    input  logic signed [DATA_WIDTH-1:0]      target,
    input  logic signed [DATA_WIDTH-1:0]      measured,
    input  logic                              angle_mode,
    input  logic                              enable,
    output logic                              out_valid,
    input  logic                              out_ready,
    output logic signed [DATA_WIDTH-1:0]      drive,
    output logic                              clamped,
    input  logic                              cfg_we,
    input  logic [pidaw_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_WIDTH-1:0]              cfg_data
);

    pidaw_pkg::dp_cmd_t    cmd;
    pidaw_pkg::dp_status_t status;

    logic signed [DATA_WIDTH-1:0] prop_gain;
    logic signed [DATA_WIDTH-1:0] integral_gain;
    logic signed [DATA_WIDTH-1:0] deriv_gain_per_period;
    logic [FRAC_BITS:0]           sample_period;
    logic signed [DATA_WIDTH-1:0] integral_upper;
    logic signed [DATA_WIDTH-1:0] integral_lower;
    logic signed [DATA_WIDTH-1:0] drive_upper;
    logic signed [DATA_WIDTH-1:0] drive_lower;

    pidaw_cfg #(
        .DATA_WIDTH (DATA_WIDTH),
        .FRAC_BITS  (FRAC_BITS),
        .CFG_WIDTH  (CFG_WIDTH)
    ) u_cfg (
        .clk                   (clk),
        .rst_n                 (rst_n),
        .cfg_we                (cfg_we),
        .cfg_index             (cfg_index),
        .cfg_data              (cfg_data),
        .prop_gain             (prop_gain),
        .integral_gain         (integral_gain),
        .deriv_gain_per_period (deriv_gain_per_period),
        .sample_period         (sample_period),
        .integral_upper        (integral_upper),
        .integral_lower        (integral_lower),
        .drive_upper           (drive_upper),
        .drive_lower           (drive_lower)
    );

    pidaw_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .cmd       (cmd),
        .status    (status)
    );

    pidaw_dp #(
        .DATA_WIDTH (DATA_WIDTH),
        .FRAC_BITS  (FRAC_BITS)
    ) u_dp (
        .clk                   (clk),
        .rst_n                 (rst_n),
        .cmd                   (cmd),
        .status                (status),
        .target                (target),
        .measured              (measured),
        .angle_mode            (angle_mode),
        .enable                (enable),
        .prop_gain             (prop_gain),
        .integral_gain         (integral_gain),
        .deriv_gain_per_period (deriv_gain_per_period),
        .sample_period         (sample_period),
        .integral_upper        (integral_upper),
        .integral_lower        (integral_lower),
        .drive_upper           (drive_upper),
        .drive_lower           (drive_lower),
        .drive                 (drive),
        .clamped               (clamped)
    );

endmodule

@@ rtl/core/pidaw_cfg.sv @@
module pidaw_cfg #(
    parameter int DATA_WIDTH = pidaw_pkg::DATA_WIDTH,
    parameter int FRAC_BITS  = pidaw_pkg::FRAC_BITS,
    parameter int CFG_WIDTH  = pidaw_pkg::DATA_WIDTH
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_we,
    input  logic [pidaw_pkg::CFG_INDEX_W-1:0]   cfg_index,
    input  logic [CFG_WIDTH-1:0]                cfg_data,
    output logic signed [DATA_WIDTH-1:0]        prop_gain,
    output logic signed [DATA_WIDTH-1:0]        integral_gain,
    output logic signed [DATA_WIDTH-1:0]        deriv_gain_per_period,
    output logic [FRAC_BITS:0]                  sample_period,
    output logic signed [DATA_WIDTH-1:0]        integral_upper,
    output logic signed [DATA_WIDTH-1:0]        integral_lower,
    output logic signed [DATA_WIDTH-1:0]        drive_upper,
    output logic signed [DATA_WIDTH-1:0]        drive_lower
);

    localparam int DW = DATA_WIDTH;
    localparam int FB = FRAC_BITS;

    // 0.02 s, rounded
    localparam logic [FB:0] PERIOD_RST =
        (FB+1)'(((64'd1 << FB) * 64'd2 + 64'd50) / 64'd100);
    localparam logic signed [DW-1:0] INT_UPPER_RST   = DW'(64'd50 << FB);
    localparam logic signed [DW-1:0] INT_LOWER_RST   = -INT_UPPER_RST;
    localparam logic signed [DW-1:0] DRIVE_UPPER_RST = DW'(64'd1 << FB);
    localparam logic signed [DW-1:0] DRIVE_LOWER_RST = -DRIVE_UPPER_RST;

    logic signed [DW-1:0] prop_gain_reg;
    logic signed [DW-1:0] integral_gain_reg;
    logic signed [DW-1:0] deriv_gain_reg;
    logic [FB:0]          sample_period_reg;
    logic signed [DW-1:0] integral_upper_reg;
    logic signed [DW-1:0] integral_lower_reg;
    logic signed [DW-1:0] drive_upper_reg;
    logic signed [DW-1:0] drive_lower_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prop_gain_reg      <= '0;
            integral_gain_reg  <= '0;
            deriv_gain_reg     <= '0;
            sample_period_reg  <= PERIOD_RST;
            integral_upper_reg <= INT_UPPER_RST;
            integral_lower_reg <= INT_LOWER_RST;
            drive_upper_reg    <= DRIVE_UPPER_RST;
            drive_lower_reg    <= DRIVE_LOWER_RST;
        end
        else if (cfg_we)
        begin
            case (pidaw_pkg::cfg_index_t'(cfg_index))
                pidaw_pkg::CFG_PROP_GAIN:      prop_gain_reg      <= cfg_data[DW-1:0];
                pidaw_pkg::CFG_INTEGRAL_GAIN:  integral_gain_reg  <= cfg_data[DW-1:0];
                pidaw_pkg::CFG_DERIV_GAIN:     deriv_gain_reg     <= cfg_data[DW-1:0];
                pidaw_pkg::CFG_SAMPLE_PERIOD:  sample_period_reg  <= cfg_data[FB:0];
                pidaw_pkg::CFG_INTEGRAL_UPPER: integral_upper_reg <= cfg_data[DW-1:0];
                pidaw_pkg::CFG_INTEGRAL_LOWER: integral_lower_reg <= cfg_data[DW-1:0];
                pidaw_pkg::CFG_DRIVE_UPPER:    drive_upper_reg    <= cfg_data[DW-1:0];
                pidaw_pkg::CFG_DRIVE_LOWER:    drive_lower_reg    <= cfg_data[DW-1:0];
                default:
                begin
                end
            endcase
        end
    end

    assign prop_gain             = prop_gain_reg;
    assign integral_gain         = integral_gain_reg;
    assign deriv_gain_per_period = deriv_gain_reg;
    assign sample_period         = sample_period_reg;
    assign integral_upper        = integral_upper_reg;
    assign integral_lower        = integral_lower_reg;
    assign drive_upper           = drive_upper_reg;
    assign drive_lower           = drive_lower_reg;

endmodule

@@ rtl/core/pidaw_ctrl.sv @@
module pidaw_ctrl (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_ready,
    output logic                  out_valid,
    input  logic                  out_ready,
    output pidaw_pkg::dp_cmd_t    cmd,
    input  pidaw_pkg::dp_status_t status
);

    typedef enum logic [10:0] {
        S_IDLE  = 11'h001,
        S_DIFF  = 11'h002,
        S_MP    = 11'h004,
        S_MI    = 11'h008,
        S_ME    = 11'h010,
        S_TRIAL = 11'h020,
        S_INTEG = 11'h040,
        S_MI2   = 11'h080,
        S_MD    = 11'h100,
        S_ACC   = 11'h200,
        S_OUT   = 11'h400
    } state_t;

    state_t state_reg, state_next;
    logic   out_valid_reg, out_valid_next;
    logic   out_free;

    assign out_free = !out_valid_reg || out_ready;
    assign in_ready = (state_reg == S_IDLE);

    always_comb
    begin
        state_next   = state_reg;
        cmd          = '0;
        cmd.mul_sel  = pidaw_pkg::MUL_NONE;
        case (state_reg)
            S_IDLE:
            begin
                cmd.ld_in = in_valid;
                if (in_valid)
                    state_next = S_DIFF;
            end
            S_DIFF:
            begin
                cmd.ld_diff = 1'b1;
                state_next  = status.enable ? S_MP : S_OUT;
            end
            S_MP:
            begin
                cmd.mul_sel = pidaw_pkg::MUL_PROP;
                state_next  = S_MI;
            end
            S_MI:
            begin
                cmd.mul_sel = pidaw_pkg::MUL_INT;
                state_next  = S_ME;
            end
            S_ME:
            begin
                cmd.mul_sel  = pidaw_pkg::MUL_PER;
                cmd.ld_pterm = 1'b1;
                state_next   = S_TRIAL;
            end
            S_TRIAL:
            begin
                cmd.ld_trial = 1'b1;
                state_next   = S_INTEG;
            end
            S_INTEG:
            begin
                cmd.ld_integ = 1'b1;
                state_next   = S_MI2;
            end
            S_MI2:
            begin
                cmd.mul_sel = pidaw_pkg::MUL_INT;
                state_next  = S_MD;
            end
            S_MD:
            begin
                cmd.mul_sel = pidaw_pkg::MUL_DERIV;
                state_next  = S_ACC;
            end
            S_ACC:
            begin
                cmd.ld_acc = 1'b1;
                state_next = S_OUT;
            end
            S_OUT:
            begin
                cmd.ld_out = out_free;
                if (out_free)
                    state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (cmd.ld_out)
            out_valid_next = 1'b1;
        else if (out_ready)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign out_valid = out_valid_reg;

    a_onehot_state: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot(state_reg))
        else $error("state register not one-hot");

    a_accept_starts: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> (state_reg == S_DIFF))
        else $error("accepted beat did not start processing");

    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_ready) |-> !cmd.ld_out)
        else $error("pending result overwritten");

    a_load_shows: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.ld_out |=> (out_valid && state_reg == S_IDLE))
        else $error("loaded result not presented");

endmodule

@@ rtl/core/pidaw_dp.sv @@
module pidaw_dp #(
    parameter int DATA_WIDTH = pidaw_pkg::DATA_WIDTH,
    parameter int FRAC_BITS  = pidaw_pkg::FRAC_BITS
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  pidaw_pkg::dp_cmd_t           cmd,
    output pidaw_pkg::dp_status_t        status,
    input  logic signed [DATA_WIDTH-1:0] target,
    input  logic signed [DATA_WIDTH-1:0] measured,
    input  logic                         angle_mode,
    input  logic                         enable,
    input  logic signed [DATA_WIDTH-1:0] prop_gain,
    input  logic signed [DATA_WIDTH-1:0] integral_gain,
    input  logic signed [DATA_WIDTH-1:0] deriv_gain_per_period,
    input  logic [FRAC_BITS:0]           sample_period,
    input  logic signed [DATA_WIDTH-1:0] integral_upper,
    input  logic signed [DATA_WIDTH-1:0] integral_lower,
    input  logic signed [DATA_WIDTH-1:0] drive_upper,
    input  logic signed [DATA_WIDTH-1:0] drive_lower,
    output logic signed [DATA_WIDTH-1:0] drive,
    output logic                         clamped
);

    localparam int DW = DATA_WIDTH;
    localparam int FB = FRAC_BITS;
    localparam int MW = (DW > FB + 2) ? DW : FB + 2;
    localparam int XW = ((DW + 1 > FB + 10) ? DW + 1 : FB + 10) + 1;

    localparam logic signed [XW-1:0] HALF_TURN = XW'(180) << FB;
    localparam logic signed [XW-1:0] FULL_TURN = XW'(360) << FB;
    localparam logic signed [DW-1:0] DMAX = {1'b0, {(DW-1){1'b1}}};
    localparam logic signed [DW-1:0] DMIN = {1'b1, {(DW-1){1'b0}}};

    function automatic logic signed [DW-1:0] sat_x(input logic signed [XW-1:0] v);
        logic [XW-DW:0] top;
        top = v[XW-1:DW-1];
        if (&top || ~|top)
            return v[DW-1:0];
        else if (v[XW-1])
            return DMIN;
        else
            return DMAX;
    endfunction

    function automatic logic signed [XW-1:0] wrap(input logic signed [XW-1:0] v);
        if (v > HALF_TURN)
            return v - FULL_TURN;
        else if (v < -HALF_TURN)
            return v + FULL_TURN;
        else
            return v;
    endfunction

    logic signed [DW-1:0]   tgt_reg, meas_reg;
    logic                   angle_reg, en_reg;
    logic signed [DW-1:0]   isum_reg, isum_next;
    logic signed [DW-1:0]   prev_reg, prev_next;
    logic signed [DW-1:0]   err_reg, chg_reg;
    logic signed [2*MW-1:0] prod_reg;
    logic signed [DW-1:0]   fx_reg, fx_next;
    logic signed [DW-1:0]   pterm_reg;
    logic                   trial_ok_reg;
    logic signed [DW:0]     acc_reg;
    logic signed [DW-1:0]   drive_reg;
    logic                   clamped_reg;

    logic signed [XW-1:0]   err_x, chg_x;
    logic signed [MW-1:0]   op_a, op_b;
    logic signed [2*MW-1:0] prod_next;
    logic [2*MW-FB-DW:0]    prod_hi;
    logic signed [DW:0]     trial, isum_sum, isum_clamp, pterm_sum;
    logic signed [DW+1:0]   total;
    logic                   trial_ok;

    always_comb
    begin
        err_x = XW'(tgt_reg) - XW'(meas_reg);
        chg_x = XW'(prev_reg) - XW'(meas_reg);
        if (angle_reg)
        begin
            err_x = wrap(err_x);
            chg_x = wrap(chg_x);
        end
    end

    always_comb
    begin
        case (cmd.mul_sel)
            pidaw_pkg::MUL_PROP:
            begin
                op_a = MW'(prop_gain);
                op_b = MW'(err_reg);
            end
            pidaw_pkg::MUL_INT:
            begin
                op_a = MW'(integral_gain);
                op_b = MW'(isum_reg);
            end
            pidaw_pkg::MUL_PER:
            begin
                op_a = MW'(err_reg);
                op_b = $signed(MW'(sample_period));
            end
            pidaw_pkg::MUL_DERIV:
            begin
                op_a = MW'(deriv_gain_per_period);
                op_b = MW'(chg_reg);
            end
            default:
            begin
                op_a = '0;
                op_b = '0;
            end
        endcase
        prod_next = op_a * op_b;
    end

    // floor shift, then saturate
    always_comb
    begin
        prod_hi = prod_reg[2*MW-1:FB+DW-1];
        if (&prod_hi || ~|prod_hi)
            fx_next = prod_reg[FB+DW-1:FB];
        else
            fx_next = prod_reg[2*MW-1] ? DMIN : DMAX;
    end

    always_comb
    begin
        trial     = (DW+1)'(pterm_reg) + (DW+1)'(fx_reg);
        trial_ok  = !(trial > (DW+1)'(drive_upper) || trial < (DW+1)'(drive_lower));
        isum_sum  = (DW+1)'(isum_reg) + (DW+1)'(fx_reg);
        if (isum_sum > (DW+1)'(integral_upper))
            isum_clamp = (DW+1)'(integral_upper);
        else if (isum_sum < (DW+1)'(integral_lower))
            isum_clamp = (DW+1)'(integral_lower);
        else
            isum_clamp = isum_sum;
        pterm_sum = (DW+1)'(pterm_reg) + (DW+1)'(fx_reg);
        total     = (DW+2)'(acc_reg) + (DW+2)'(fx_reg);
    end

    always_comb
    begin
        isum_next = isum_reg;
        prev_next = prev_reg;
        if (cmd.ld_integ && trial_ok_reg)
            isum_next = isum_clamp[DW-1:0];
        if (cmd.ld_out)
        begin
            prev_next = meas_reg;
            if (!en_reg)
                isum_next = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            isum_reg <= '0;
            prev_reg <= '0;
        end
        else
        begin
            isum_reg <= isum_next;
            prev_reg <= prev_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.ld_in)
        begin
            tgt_reg   <= target;
            meas_reg  <= measured;
            angle_reg <= angle_mode;
            en_reg    <= enable;
        end
        if (cmd.ld_diff)
        begin
            err_reg <= sat_x(err_x);
            chg_reg <= sat_x(chg_x);
        end
        if (cmd.mul_sel != pidaw_pkg::MUL_NONE)
            prod_reg <= prod_next;
        fx_reg <= fx_next;
        if (cmd.ld_pterm)
            pterm_reg <= fx_reg;
        if (cmd.ld_trial)
            trial_ok_reg <= trial_ok;
        if (cmd.ld_acc)
            acc_reg <= pterm_sum;
        if (cmd.ld_out)
        begin
            if (!en_reg)
            begin
                drive_reg   <= '0;
                clamped_reg <= 1'b0;
            end
            else if (total > (DW+2)'(drive_upper))
            begin
                drive_reg   <= drive_upper;
                clamped_reg <= 1'b1;
            end
            else if (total < (DW+2)'(drive_lower))
            begin
                drive_reg   <= drive_lower;
                clamped_reg <= 1'b1;
            end
            else
            begin
                drive_reg   <= total[DW-1:0];
                clamped_reg <= 1'b0;
            end
        end
    end

    assign status.enable = en_reg;
    assign drive         = drive_reg;
    assign clamped       = clamped_reg;

endmodule
